>>> sv/diff_pressure_frame_decoder_macros.svh
// Assertion macros shared by the differential pressure frame decoder checkers.
`ifndef DIFF_PRESSURE_FRAME_DECODER_MACROS_SVH
`define DIFF_PRESSURE_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define DPFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define DPFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dpfd_pkg.sv
// Types and constants of the differential pressure frame decoder.
package dpfd_pkg;

  // Result codes.
  localparam logic [2:0] CODE_NEW      = 3'd0;
  localparam logic [2:0] CODE_SAME     = 3'd1;
  localparam logic [2:0] CODE_BUS      = 3'd2;
  localparam logic [2:0] CODE_RESERVED = 3'd3;
  localparam logic [2:0] CODE_STALE    = 3'd4;
  localparam logic [2:0] CODE_FAULT    = 3'd5;
  localparam logic [2:0] CODE_BAD_TEMP = 3'd6;

  // Sensor status field.
  localparam logic [1:0] STATUS_NORMAL   = 2'd0;
  localparam logic [1:0] STATUS_RESERVED = 2'd1;
  localparam logic [1:0] STATUS_STALE    = 2'd2;
  localparam logic [1:0] STATUS_FAULT    = 2'd3;

  localparam logic [10:0] TEMP_INVALID = 11'd2047;
  localparam logic [14:0] PRESS_SPAN   = 15'd16383;
  localparam logic [15:0] ERR_MAX      = 16'hFFFF;

  // Pressure: q = floor(mag * 6894757 / 819150 + 1/2). The reciprocal is rounded up;
  // with 34 fraction bits its error stays below the 1/819150 spacing of the result.
  localparam int unsigned PRESS_SHIFT = 34;
  localparam int unsigned PRESS_LO_W  = 19;
  localparam logic [63:0] PRESS_RECIP =
    ((64'd6894757 << PRESS_SHIFT) + 64'd819150 - 64'd1) / 64'd819150;
  localparam logic [18:0] PRESS_RECIP_LO = PRESS_RECIP[18:0];
  localparam logic [18:0] PRESS_RECIP_HI = PRESS_RECIP[37:19];
  localparam logic [33:0] PRESS_HALF     = 34'h2_0000_0000;

  // Temperature: q = floor((51200 * t + 1023) / 2047), both constants rounded up.
  localparam int unsigned TEMP_SHIFT = 24;
  localparam logic [63:0] TEMP_RECIP =
    ((64'd51200 << TEMP_SHIFT) + 64'd2046) / 64'd2047;
  localparam logic [63:0] TEMP_ROUND =
    ((64'd1023 << TEMP_SHIFT) + 64'd2046) / 64'd2047;
  localparam logic signed [16:0] TEMP_OFFSET = 17'sd12800;

  // Classified frame handed from the decode stage to the scaling pipeline.
  typedef struct packed {
    logic [2:0]  code;
    logic        neg;
    logic [13:0] mag;
    logic [10:0] tcount;
    logic [15:0] err_total;
  } item_t;

endpackage

>>> sv/dpfd_if.sv
// Valid/ready channel interfaces for frames in and decoded readings out.
interface dpfd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame;
  logic        bus_failed;

  modport source (output valid, output frame, output bus_failed, input ready);
  modport sink (input valid, input frame, input bus_failed, output ready);
endinterface

interface dpfd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         result_code;
  logic signed [18:0] pressure_sixteenth_pa;
  logic signed [16:0] temperature_q8;
  logic [15:0]        error_total;

  modport source (output valid, output result_code, output pressure_sixteenth_pa,
                  output temperature_q8, output error_total, input ready);
  modport sink (input valid, input result_code, input pressure_sixteenth_pa,
                input temperature_q8, input error_total, output ready);
endinterface

>>> sv/dpfd_classify.sv
// Frame classification, change detection and the saturating error counter.
module dpfd_classify (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [31:0]     frame,
  input  logic            bus_failed,
  output dpfd_pkg::item_t item
);

  logic [13:0] last_p_r, last_p_nxt;
  logic [10:0] last_t_r, last_t_nxt;
  logic [15:0] err_r, err_nxt;

  logic [1:0]  status;
  logic [13:0] p;
  logic [10:0] t;
  logic [14:0] twice_p;
  logic [14:0] diff;
  logic        bump;
  logic        take;
  logic [2:0]  code;

  assign status  = frame[31:30];
  assign p       = frame[29:16];
  assign t       = frame[15:5];
  assign twice_p = {p, 1'b0};

  // The signed span 16383 - 2P changes sign exactly when the top count bit is set.
  assign diff = p[13] ? (twice_p - dpfd_pkg::PRESS_SPAN) : (dpfd_pkg::PRESS_SPAN - twice_p);

  always_comb begin
    bump = 1'b0;
    take = 1'b0;
    code = dpfd_pkg::CODE_SAME;
    if (bus_failed) begin
      bump = 1'b1;
      code = dpfd_pkg::CODE_BUS;
    end else begin
      unique case (status)
        dpfd_pkg::STATUS_RESERVED: code = dpfd_pkg::CODE_RESERVED;
        dpfd_pkg::STATUS_STALE:    code = dpfd_pkg::CODE_STALE;
        dpfd_pkg::STATUS_FAULT: begin
          bump = 1'b1;
          code = dpfd_pkg::CODE_FAULT;
        end
        default: begin
          if (t == dpfd_pkg::TEMP_INVALID) begin
            bump = 1'b1;
            code = dpfd_pkg::CODE_BAD_TEMP;
          end else if (p != last_p_r || t != last_t_r) begin
            take = 1'b1;
            code = dpfd_pkg::CODE_NEW;
          end
        end
      endcase
    end
  end

  assign err_nxt    = (bump && err_r != dpfd_pkg::ERR_MAX) ? err_r + 16'd1 : err_r;
  assign last_p_nxt = take ? p : last_p_r;
  assign last_t_nxt = take ? t : last_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_p_r <= '0;
      last_t_r <= '0;
      err_r    <= '0;
    end else if (accept) begin
      last_p_r <= last_p_nxt;
      last_t_r <= last_t_nxt;
      err_r    <= err_nxt;
    end
  end

  assign item.code      = code;
  assign item.neg       = p[13];
  assign item.mag       = diff[13:0];
  assign item.tcount    = t;
  assign item.err_total = err_nxt;

endmodule

>>> sv/diff_pressure_frame_decoder.sv
// Differential pressure frame decoder: classify into an input register, scale into the output.
// A frame is held in the input register and then in the output register before it is offered.
// Throughput: one frame per cycle; the input and output registers each take a new item
// every cycle and stall only when full while the register after them cannot take it.
// Reset (synchronous, rst_n low) empties both registers and zeroes the last counts and
// the error counter.
module diff_pressure_frame_decoder (
  input logic        clk,
  input logic        rst_n,
  dpfd_in_if.sink    in_ch,
  dpfd_out_if.source out_ch
);

  dpfd_pkg::item_t item;
  logic            accept;
  logic            s1_rdy, out_rdy;

  // Input register: classified item.
  logic            s1_v_r, s1_v_nxt;
  dpfd_pkg::item_t s1_r;

  // Scaling logic between the two registers.
  logic [32:0]        pp_hi;
  logic [33:0]        pp_lo;
  logic [52:0]        press_sum;
  logic [17:0]        press_q;
  logic [40:0]        temp_sum;
  logic [15:0]        temp_q;
  logic signed [18:0] press_val;
  logic signed [16:0] temp_val;

  // Output register.
  logic               out_v_r, out_v_nxt;
  logic [2:0]         out_code_r;
  logic signed [18:0] out_press_r;
  logic signed [16:0] out_temp_r;
  logic [15:0]        out_err_r;

  assign out_rdy = !out_v_r || out_ch.ready;
  assign s1_rdy  = !s1_v_r || out_rdy;
  assign in_ch.ready = s1_rdy;
  assign accept  = in_ch.valid && s1_rdy;

  dpfd_classify u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .frame      (in_ch.frame),
    .bus_failed (in_ch.bus_failed),
    .item       (item)
  );

  assign s1_v_nxt  = s1_rdy ? in_ch.valid : s1_v_r;
  assign out_v_nxt = out_rdy ? s1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= item;
    end
  end

  // Pressure reciprocal in two 19-bit halves; the rounding half rides on the low half.
  assign pp_hi    = 33'(s1_r.mag) * 33'(dpfd_pkg::PRESS_RECIP_HI);
  assign pp_lo    = 34'(33'(s1_r.mag) * 33'(dpfd_pkg::PRESS_RECIP_LO))
                    + dpfd_pkg::PRESS_HALF;
  assign temp_sum = 41'(s1_r.tcount) * 41'(dpfd_pkg::TEMP_RECIP)
                    + 41'(dpfd_pkg::TEMP_ROUND);
  assign temp_q   = temp_sum[dpfd_pkg::TEMP_SHIFT +: 16];

  assign press_sum = 53'({pp_hi, {dpfd_pkg::PRESS_LO_W{1'b0}}}) + 53'(pp_lo);
  assign press_q   = press_sum[dpfd_pkg::PRESS_SHIFT +: 18];

  always_comb begin
    press_val = '0;
    temp_val  = '0;
    if (s1_r.code == dpfd_pkg::CODE_NEW) begin
      press_val = s1_r.neg ? -$signed({1'b0, press_q}) : $signed({1'b0, press_q});
      temp_val  = $signed({1'b0, temp_q}) - dpfd_pkg::TEMP_OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && out_rdy) begin
      out_code_r  <= s1_r.code;
      out_press_r <= press_val;
      out_temp_r  <= temp_val;
      out_err_r   <= s1_r.err_total;
    end
  end

  assign out_ch.valid                 = out_v_r;
  assign out_ch.result_code           = out_code_r;
  assign out_ch.pressure_sixteenth_pa = out_press_r;
  assign out_ch.temperature_q8        = out_temp_r;
  assign out_ch.error_total           = out_err_r;

endmodule

>>> sv/dpfd_checker.sv
// Port-level checker for the differential pressure frame decoder, with its bind.
`include "diff_pressure_frame_decoder_macros.svh"

module dpfd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         result_code,
  input logic signed [18:0] pressure_sixteenth_pa,
  input logic signed [16:0] temperature_q8,
  input logic [15:0]        error_total
);

  logic       in_xfer, out_xfer;
  logic [1:0] pend_r, pend_nxt;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Items accepted but not yet delivered; the block holds at most two.
  assign pend_nxt = pend_r + 2'(in_xfer) - 2'(out_xfer);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `DPFD_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(result_code) && $stable(pressure_sixteenth_pa) &&
    $stable(temperature_q8) && $stable(error_total), "stalled result changed")

  `DPFD_ASSERT_IMP(a_no_phantom, out_valid, pend_r != 2'd0,
    "result shown without an accepted frame")

  `DPFD_ASSERT_IMP(a_quiet_fields, out_valid && result_code != dpfd_pkg::CODE_NEW,
    pressure_sixteenth_pa == 19'sd0 && temperature_q8 == 17'sd0,
    "reading fields nonzero on a result that is not new")

  `DPFD_ASSERT_IMP(a_bus_counted, out_valid && result_code == dpfd_pkg::CODE_BUS,
    error_total != 16'd0, "bus error left the error count at zero")

endmodule

bind diff_pressure_frame_decoder dpfd_checker u_dpfd_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_ch.valid),
  .in_ready              (in_ch.ready),
  .out_valid             (out_ch.valid),
  .out_ready             (out_ch.ready),
  .result_code           (out_ch.result_code),
  .pressure_sixteenth_pa (out_ch.pressure_sixteenth_pa),
  .temperature_q8        (out_ch.temperature_q8),
  .error_total           (out_ch.error_total)
);
